// ----- hdl/hpa_pkg.sv -----
// Types and constants shared by the heater PID autotuner.
package hpa_pkg;

  typedef struct packed {
    logic               running;
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
    logic        [15:0] tick_ms;
  } tick_t;

  typedef struct packed {
    logic [7:0]  heat_drive;
    logic        tuning_done;
    logic [15:0] ultimate_gain;
    logic [31:0] ultimate_period_ms;
    logic [15:0] prop_gain;
    logic [26:0] integ_gain;
    logic [35:0] deriv_gain;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MLOAD,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_STORE,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_DRIVE,
    OP_PROP,
    OP_INTEG,
    OP_DERIV
  } op_t;

  localparam logic [15:0] GAIN_START  = 16'd100;
  localparam logic [15:0] GAIN_STEP   = 16'd8;
  localparam logic [15:0] GAIN_MAX    = 16'd65535;
  localparam logic [7:0]  DRIVE_MAX   = 8'd200;
  localparam logic [26:0] INTEG_MAX   = 27'd131070000;

  // Width of the product and of the divider's dividend, and shift-add steps.
  localparam int PROD_W = 48;
  localparam int MUL_N  = 16;

  // gain * error at or above this gives a drive of at least DRIVE_MAX.
  localparam logic [47:0] DRIVE_LIMIT = 48'd100000;

  localparam int DRIVE_DIV = 500;
  localparam int PROP_MUL  = 6;
  localparam int PROP_DIV  = 10;
  localparam int INTEG_MUL = 2000;
  localparam int DERIV_DIV = 8000;

  // Significant dividend bits for each quotient, which sets its step count.
  localparam int DIV_N_DRIVE = 17;
  localparam int DIV_N_PROP  = 19;
  localparam int DIV_N_INTEG = 27;
  localparam int DIV_N_DERIV = 48;

endpackage

// ----- hdl/heater_pid_autotuner_unit.sv -----
// Heater autotuner: proportional trial drive, crossing timer and gain derivation.
//
// Each accepted tick item yields at most one result item. A running tick goes
// through one 16-step shift-add multiply and one 17-step restoring divide on
// the shared bit-serial multiplier and divider, plus load, store and output
// states. The tick on which tuning completes runs three more multiply and
// divide passes (for Kp, Ki and Kd, with 19, 27 and 48 divide steps). A stop
// tick goes straight to output; a tick with a zero setpoint, or one that
// arrives after tuning, is absorbed with no result. The input stalls while an
// item is being worked on; the output register lets the next tick enter
// while a result item is still waiting to be taken.
module heater_pid_autotuner_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            tick_valid,
  output logic            tick_stall,
  input  hpa_pkg::tick_t  tick,
  output logic            result_valid,
  input  logic            result_stall,
  output hpa_pkg::result_t result
);
  import hpa_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  logic               tuned;
  logic [15:0]        trial_gain;
  logic signed [15:0] prev_measured;
  logic [31:0]        elapsed_ms;
  logic               crossing_count;
  logic [31:0]        cross_time;

  // Operands captured from the accepted tick.
  logic [15:0] ku;
  logic [15:0] err;
  logic [31:0] tu;
  logic        drive_sat;
  result_t     res;

  // Shared bit-serial multiplier and divider.
  logic [5:0]        cnt;
  logic [31:0]       mcand;
  logic [PROD_W-1:0] mul_acc;
  logic [31:0]       mul_add;
  logic [32:0]       mul_sum;
  logic [PROD_W-1:0] dvd;
  logic [31:0]       rem;
  logic [31:0]       divisor;
  logic [32:0]       div_shift;
  logic [32:0]       div_diff;
  logic              div_ge;

  logic        take;
  logic        emit_load;
  logic        crossing;
  logic        below;
  logic [16:0] err_diff;
  logic [16:0] gain_sum;

  assign take     = tick_valid && !tick_stall;
  assign crossing = (tick.measured > tick.setpoint) && (prev_measured < tick.setpoint);
  assign below    = tick.measured < tick.setpoint;
  assign err_diff = {tick.setpoint[15], tick.setpoint} - {tick.measured[15], tick.measured};
  assign gain_sum = {1'b0, trial_gain} + {1'b0, GAIN_STEP};

  assign mul_add   = mul_acc[0] ? mcand : 32'd0;
  assign mul_sum   = {1'b0, mul_acc[PROD_W-1:MUL_N]} + {1'b0, mul_add};
  assign div_shift = {rem, dvd[PROD_W-1]};
  assign div_ge    = div_shift >= {1'b0, divisor};
  assign div_diff  = div_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_DRIVE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    tick_stall = 1'b1;
    emit_load  = 1'b0;
    case (state)
      S_IDLE: begin
        tick_stall = 1'b0;
        if (tick_valid) begin
          if (!tick.running) begin
            state_next = S_EMIT;
          end else if (tick.setpoint != 16'sd0 && !tuned) begin
            state_next = S_MLOAD;
            op_next    = OP_DRIVE;
          end
        end
      end
      S_MLOAD: state_next = S_MUL;
      S_MUL: begin
        if (cnt == 6'd1) state_next = S_DLOAD;
      end
      S_DLOAD: state_next = S_DIV;
      S_DIV: begin
        if (cnt == 6'd1) state_next = S_STORE;
      end
      S_STORE: begin
        // Only the tick that completes tuning goes on to the derived gains.
        if (res.tuning_done && op != OP_DERIV) begin
          state_next = S_MLOAD;
          case (op)
            OP_DRIVE: op_next = OP_PROP;
            OP_PROP:  op_next = OP_INTEG;
            default:  op_next = OP_DERIV;
          endcase
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!result_valid || !result_stall) begin
          emit_load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Tuning state is updated as the tick is accepted; the work that follows
  // uses the captured copies.
  always_ff @(posedge clk) begin
    if (rst) begin
      tuned          <= 1'b0;
      trial_gain     <= GAIN_START;
      prev_measured  <= '0;
      elapsed_ms     <= '0;
      crossing_count <= 1'b0;
      cross_time     <= '0;
    end else if (take) begin
      if (!tick.running) begin
        tuned          <= 1'b0;
        elapsed_ms     <= '0;
        crossing_count <= 1'b0;
      end else if (tick.setpoint != 16'sd0 && !tuned) begin
        prev_measured <= tick.measured;
        elapsed_ms    <= elapsed_ms + {16'd0, tick.tick_ms};
        if (crossing && crossing_count) begin
          crossing_count <= 1'b0;
          tuned          <= 1'b1;
          trial_gain     <= GAIN_START;
        end else begin
          if (crossing) begin
            cross_time     <= elapsed_ms;
            crossing_count <= 1'b1;
          end
          if (below) begin
            trial_gain <= gain_sum[16] ? GAIN_MAX : gain_sum[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (state)
        S_MLOAD: cnt <= 6'(MUL_N);
        S_DLOAD: begin
          case (op)
            OP_DRIVE: cnt <= 6'(DIV_N_DRIVE);
            OP_PROP:  cnt <= 6'(DIV_N_PROP);
            OP_INTEG: cnt <= 6'(DIV_N_INTEG);
            default:  cnt <= 6'(DIV_N_DERIV);
          endcase
        end
        S_MUL, S_DIV: cnt <= cnt - 6'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ku  <= trial_gain;
      err <= below ? err_diff[15:0] : 16'd0;
      if (tick.running && crossing && crossing_count) begin
        tu  <= elapsed_ms - cross_time;
        res <= '{tuning_done: 1'b1, ultimate_gain: trial_gain,
                 ultimate_period_ms: elapsed_ms - cross_time, default: '0};
      end else begin
        res <= '0;
      end
    end
    case (state)
      S_MLOAD: begin
        mul_acc <= {32'd0, ku};
        case (op)
          OP_DRIVE: mcand <= {16'd0, err};
          OP_PROP:  mcand <= 32'(PROP_MUL);
          OP_INTEG: mcand <= 32'(INTEG_MUL);
          default:  mcand <= tu;
        endcase
      end
      S_MUL: mul_acc <= {mul_sum, mul_acc[MUL_N-1:1]};
      S_DLOAD: begin
        rem       <= '0;
        drive_sat <= mul_acc >= DRIVE_LIMIT;
        case (op)
          OP_DRIVE: begin
            dvd     <= mul_acc << (PROD_W - DIV_N_DRIVE);
            divisor <= 32'(DRIVE_DIV);
          end
          OP_PROP: begin
            dvd     <= mul_acc << (PROD_W - DIV_N_PROP);
            divisor <= 32'(PROP_DIV);
          end
          OP_INTEG: begin
            dvd     <= mul_acc << (PROD_W - DIV_N_INTEG);
            divisor <= tu;
          end
          default: begin
            dvd     <= mul_acc;
            divisor <= 32'(DERIV_DIV);
          end
        endcase
      end
      S_DIV: begin
        rem <= div_ge ? div_diff[31:0] : div_shift[31:0];
        dvd <= {dvd[PROD_W-2:0], div_ge};
      end
      S_STORE: begin
        case (op)
          OP_DRIVE: res.heat_drive <= drive_sat ? DRIVE_MAX : dvd[7:0];
          OP_PROP:  res.prop_gain  <= dvd[15:0];
          OP_INTEG: res.integ_gain <= (tu == 32'd0) ? INTEG_MAX : dvd[26:0];
          default:  res.deriv_gain <= dvd[35:0];
        endcase
      end
      default: ;
    endcase
    if (emit_load) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.heat_drive <= DRIVE_MAX)
    else $error("heat drive above its ceiling");

  a_untuned_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.tuning_done |->
      result.ultimate_gain == 16'd0 && result.ultimate_period_ms == 32'd0 &&
      result.prop_gain == 16'd0 && result.integ_gain == 27'd0 &&
      result.deriv_gain == 36'd0)
    else $error("gain fields set on an item that did not finish tuning");

  a_prop_below_ku: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.tuning_done |-> result.prop_gain <= result.ultimate_gain)
    else $error("proportional gain exceeds ultimate gain");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    tick_valid && !tick_stall && !tick.running |=>
      !tuned && !crossing_count && elapsed_ms == 32'd0)
    else $error("stop tick did not clear the tuning state");

  a_gain_floor: assert property (@(posedge clk) disable iff (rst)
    trial_gain >= GAIN_START)
    else $error("trial gain fell below its starting value");

endmodule
